>>> hdl/dsa_pkg.sv
`default_nettype none

package dsa_pkg;

    typedef struct packed {
        logic               action;
        logic signed [31:0] value_a;
        logic signed [7:0]  scale_a;
        logic signed [31:0] value_b;
        logic signed [7:0]  scale_b;
    } dsa_in_t;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] result_value;
        logic signed [7:0]  result_scale;
    } dsa_out_t;

    // actions carried in the action field
    localparam logic ACT_RESCALE = 1'b0;
    localparam logic ACT_ADD     = 1'b1;

    // command to the shared decimal step unit
    typedef struct packed {
        logic               mul;
        logic signed [31:0] value;
    } dsa_step_cmd_t;

    typedef struct packed {
        logic               over;
        logic signed [31:0] value;
    } dsa_step_rsp_t;

    // a mantissa at or beyond this magnitude is treated as unable to take another times ten
    localparam logic signed [31:0] DEC_BOUND_HI = 32'sd214748364;
    localparam logic signed [31:0] DEC_BOUND_LO = -32'sd214748364;

    // floor(m / 10) == (m * RECIP10) >> RECIP10_SHIFT for any unsigned 32-bit m
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int unsigned RECIP10_SHIFT = 35;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_STEP_A = 4'b0010,
        ST_STEP_B = 4'b0100,
        ST_SUM    = 4'b1000
    } dsa_state_t;

endpackage

`default_nettype wire

>>> hdl/dsa_if.sv
`default_nettype none

interface dsa_in_if;
    logic             valid;
    logic             ready;
    dsa_pkg::dsa_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dsa_out_if;
    logic              valid;
    logic              ready;
    dsa_pkg::dsa_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/dsa_step_unit.sv
`default_nettype none

module dsa_step_unit (
    input  dsa_pkg::dsa_step_cmd_t cmd,
    output dsa_pkg::dsa_step_rsp_t rsp
);
    import dsa_pkg::*;

    logic [31:0]        mag;
    logic [63:0]        prod;
    logic [28:0]        quot;
    logic signed [31:0] times_ten;
    logic signed [31:0] div_ten;

    always_comb
    begin
        // times ten as two shifts and an add
        times_ten = (cmd.value <<< 3) + (cmd.value <<< 1);

        // magnitude of the most negative value still fits unsigned
        mag  = cmd.value[31] ? (32'd0 - cmd.value) : cmd.value;
        prod = {32'd0, mag} * {32'd0, RECIP10};
        quot = prod[63:RECIP10_SHIFT];
        div_ten = cmd.value[31] ? (32'sd0 - $signed({3'b000, quot}))
                                : $signed({3'b000, quot});

        rsp.over  = cmd.mul && (cmd.value >= DEC_BOUND_HI || cmd.value <= DEC_BOUND_LO);
        rsp.value = cmd.mul ? times_ten : div_ten;
    end

endmodule

`default_nettype wire

>>> hdl/decimal_scaled_add_unit.sv
`default_nettype none

// channel  dir  payload                                   transaction when
// req      in   action, value_a, scale_a, value_b, scale_b  valid && ready
// rsp      out  ok, result_value, result_scale             valid && ready
//
// one transaction at a time: after accept, n_a steps on operand a, then n_b steps on operand b, then the sum, where
// n_a and n_b are the times-ten or divide-by-ten steps each operand takes
// (at most 10 each, fewer once the mantissa is zero or overflows)
// the steps run one per cycle through a single shared decimal step unit
// reset clears the sequencer and the result valid, payload registers are not reset
// a result waiting on rsp does not block the next accept, it stalls only the final sum

module decimal_scaled_add_unit (
    input  wire          clk,
    input  wire          rst_n,
    dsa_in_if.sink       req,
    dsa_out_if.source    rsp
);
    import dsa_pkg::*;

    dsa_state_t         state_reg, state_next;
    logic signed [31:0] va_reg, va_next;
    logic signed [31:0] vb_reg, vb_next;
    logic [7:0]         cnt_a_reg, cnt_a_next;
    logic [7:0]         cnt_b_reg, cnt_b_next;
    logic               mul_a_reg, mul_a_next;
    logic signed [7:0]  rs_reg, rs_next;
    logic               fail_reg, fail_next;
    logic               out_valid_reg, out_valid_next;
    dsa_out_t           out_reg, out_next;

    dsa_step_cmd_t      step_cmd;
    dsa_step_rsp_t      step_rsp;

    logic signed [7:0]  tgt;
    logic signed [8:0]  diff_a;
    logic signed [8:0]  diff_b;
    logic signed [32:0] sum;
    logic               sum_ovf;
    logic               out_free;

    dsa_step_unit u_step (
        .cmd (step_cmd),
        .rsp (step_rsp)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    always_comb
    begin
        // target scale and step counts for an incoming transaction
        tgt = (req.data.action == ACT_ADD && req.data.scale_a < req.data.scale_b)
              ? req.data.scale_a : req.data.scale_b;
        diff_a = 9'(req.data.scale_a) - 9'(tgt);
        diff_b = (req.data.action == ACT_ADD) ? (9'(req.data.scale_b) - 9'(tgt)) : 9'sd0;

        // operand b only ever moves down, so only a carries a direction
        step_cmd.mul   = (state_reg == ST_STEP_A) ? mul_a_reg : 1'b1;
        step_cmd.value = (state_reg == ST_STEP_A) ? va_reg : vb_reg;

        sum      = 33'(va_reg) + 33'(vb_reg);
        sum_ovf  = sum[32] != sum[31];
        out_free = !out_valid_reg || rsp.ready;

        state_next     = state_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        mul_a_next     = mul_a_reg;
        rs_next        = rs_reg;
        fail_next      = fail_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_next       = out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    va_next    = req.data.value_a;
                    vb_next    = (req.data.action == ACT_ADD) ? req.data.value_b : 32'sd0;
                    rs_next    = tgt;
                    mul_a_next = !diff_a[8];
                    cnt_a_next = diff_a[8] ? 8'(-diff_a) : diff_a[7:0];
                    cnt_b_next = diff_b[7:0];
                    fail_next  = 1'b0;
                    state_next = ST_STEP_A;
                end
            end
            ST_STEP_A:
            begin
                if (cnt_a_reg == 8'd0 || va_reg == 32'sd0)
                    state_next = ST_STEP_B;
                else if (step_rsp.over)
                begin
                    fail_next  = 1'b1;
                    state_next = ST_SUM;
                end
                else
                begin
                    va_next    = step_rsp.value;
                    cnt_a_next = cnt_a_reg - 8'd1;
                end
            end
            ST_STEP_B:
            begin
                if (cnt_b_reg == 8'd0 || vb_reg == 32'sd0)
                    state_next = ST_SUM;
                else if (step_rsp.over)
                begin
                    fail_next  = 1'b1;
                    state_next = ST_SUM;
                end
                else
                begin
                    vb_next    = step_rsp.value;
                    cnt_b_next = cnt_b_reg - 8'd1;
                end
            end
            ST_SUM:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next.ok    = !fail_reg && !sum_ovf;
                    out_next.result_value = (!fail_reg && !sum_ovf) ? sum[31:0] : 32'sd0;
                    out_next.result_scale = (!fail_reg && !sum_ovf) ? rs_reg : 8'sd0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        va_reg    <= va_next;
        vb_reg    <= vb_next;
        cnt_a_reg <= cnt_a_next;
        cnt_b_reg <= cnt_b_next;
        mul_a_reg <= mul_a_next;
        rs_reg    <= rs_next;
        fail_reg  <= fail_next;
        out_reg   <= out_next;
    end

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
    import dsa_pkg::*;

    localparam longint TIMES_TEN_LIMIT = 64'sd214748364;
    localparam longint I32_TOP         = 64'sd2147483647;
    localparam longint I32_BOTTOM      = -64'sd2147483648;
    localparam int     QUIET_LIMIT     = 2000;
    localparam int     RANDOM_ITEMS    = 1627;
    localparam int     FIRST_DRAIN     = 23;
    localparam int     SECOND_DRAIN    = 900;

    logic clk = 1'b0;
    logic rst_n;

    dsa_in_if  req ();
    dsa_out_if rsp ();

    decimal_scaled_add_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #2 clk = ~clk;

    dsa_in_t  pending_ops[$];
    dsa_out_t results_due[$];

    int sent_count     = 0;
    int rescale_count  = 0;
    int add_count      = 0;
    int checked_count  = 0;
    int overflow_count = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;

    // moves a mantissa between decimal scales, 0 when a times-ten step overflows
    function automatic bit move_scale(input longint m, input int from_s, input int to_s,
                                      output longint moved);
        moved = m;
        if (from_s > to_s) begin
            for (int k = 0; k < from_s - to_s; k++) begin
                if (moved >= TIMES_TEN_LIMIT || moved <= -TIMES_TEN_LIMIT)
                    return 1'b0;
                moved = moved * 10;
            end
        end else begin
            for (int k = 0; k < to_s - from_s && moved != 0; k++)
                moved = moved / 10;
        end
        return 1'b1;
    endfunction

    function automatic dsa_out_t decimal_result(input dsa_in_t op);
        dsa_out_t r;
        longint   ma;
        longint   mb;
        longint   total;
        int       sa;
        int       sb;
        int       target;
        bit       fine;
        sa = op.scale_a;
        sb = op.scale_b;
        total = 0;
        if (op.action == ACT_RESCALE) begin
            target = sb;
            fine = move_scale(op.value_a, sa, sb, total);
        end else begin
            target = (sa < sb) ? sa : sb;
            fine = move_scale(op.value_a, sa, target, ma);
            if (fine)
                fine = move_scale(op.value_b, sb, target, mb);
            if (fine) begin
                total = ma + mb;
                if (total > I32_TOP || total < I32_BOTTOM)
                    fine = 1'b0;
            end
        end
        r.ok           = fine;
        r.result_value = fine ? total[31:0] : '0;
        r.result_scale = fine ? target[7:0] : '0;
        return r;
    endfunction

    task automatic queue_item(input logic act, input int va, input int sa,
                              input int vb, input int sb);
        dsa_in_t op;
        op.action  = act;
        op.value_a = va;
        op.scale_a = sa[7:0];
        op.value_b = vb;
        op.scale_b = sb[7:0];
        pending_ops.push_back(op);
    endtask

    function automatic int pick_mantissa();
        int m;
        case ($urandom_range(5))
            0: m = $urandom();
            1: m = int'($urandom_range(2000)) - 1000;
            2:
            begin
                // right around the times-ten limit
                m = 214748364 + int'($urandom_range(6)) - 3;
                if ($urandom_range(1))
                    m = -m;
            end
            3: m = 0;
            4:
            begin
                case ($urandom_range(3))
                    0: m = 32'h7FFF_FFFF;
                    1: m = 32'h8000_0000;
                    2: m = 1;
                    default: m = -1;
                endcase
            end
            default:
            begin
                m = int'($urandom() >> $urandom_range(31));
                if ($urandom_range(1))
                    m = -m;
            end
        endcase
        return m;
    endfunction

    function automatic int clamp_scale(input int s);
        if (s > 127)
            return 127;
        if (s < -128)
            return -128;
        return s;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic int send_idle_pct();
        if (sent_count < 550)
            return 10;
        if (sent_count < 1100)
            return 85;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (sent_count < 550)
            return 85;
        if (sent_count < 1100)
            return 10;
        return 0;
    endfunction

    // driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (req.valid && req.ready) begin
                results_due.push_back(decimal_result(req.data));
                if (req.data.action == ACT_RESCALE)
                    rescale_count++;
                else
                    add_count++;
                sent_count++;
            end
            if (!req.valid || req.ready) begin
                // hold off at the drain points until everything in flight has returned
                if (pending_ops.size() != 0
                    && !((sent_count == FIRST_DRAIN || sent_count == SECOND_DRAIN)
                         && results_due.size() != 0)
                    && $urandom_range(99) >= send_idle_pct()) begin
                    req.valid <= 1'b1;
                    req.data  <= pending_ops.pop_front();
                end else begin
                    req.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        dsa_out_t want;
        if (rst_n) begin
            if (rsp.valid && rsp.ready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result with no transaction outstanding",
                                    rsp.data.result_value, 0);
                end else begin
                    want = results_due.pop_front();
                    if (rsp.data.ok !== want.ok)
                        report_mismatch("ok", rsp.data.ok, want.ok);
                    if (rsp.data.result_value !== want.result_value)
                        report_mismatch("result_value", rsp.data.result_value,
                                        want.result_value);
                    if (rsp.data.result_scale !== want.result_scale)
                        report_mismatch("result_scale", rsp.data.result_scale,
                                        want.result_scale);
                    if (!want.ok)
                        overflow_count++;
                end
                checked_count++;
            end
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct());
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
                $display("Some tests failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int sa;
        int sb;
        rst_n     = 1'b0;
        req.valid = 1'b0;
        req.data  = '0;
        rsp.ready = 1'b0;

        // rescale corners
        queue_item(ACT_RESCALE, 12345, 3, 0, 3);
        queue_item(ACT_RESCALE, 214748363, 1, 0, 0);
        queue_item(ACT_RESCALE, 214748364, 1, 0, 0);
        queue_item(ACT_RESCALE, -214748363, 0, 0, -1);
        queue_item(ACT_RESCALE, -214748364, 0, 0, -1);
        queue_item(ACT_RESCALE, 1, 9, 0, 0);
        queue_item(ACT_RESCALE, 1, 10, 0, 0);
        queue_item(ACT_RESCALE, 0, 127, 0, -128);
        queue_item(ACT_RESCALE, 32'h8000_0000, -128, 0, 127);
        queue_item(ACT_RESCALE, -19, 0, 0, 1);
        queue_item(ACT_RESCALE, 32'h7FFF_FFFF, -5, -1, 5);
        queue_item(ACT_RESCALE, 32'h7FFF_FFFF, -128, 32'h8000_0000, -128);
        queue_item(ACT_RESCALE, 999, -128, 0, 127);
        // add corners
        queue_item(ACT_ADD, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0);
        queue_item(ACT_ADD, 32'h8000_0000, 0, 32'h8000_0000, 0);
        queue_item(ACT_ADD, 32'h7FFF_FFFF, 0, 0, 0);
        queue_item(ACT_ADD, 32'h8000_0000, 0, -1, 0);
        queue_item(ACT_ADD, 32'h8000_0000, 0, 32'h7FFF_FFFF, 0);
        queue_item(ACT_ADD, 5, 2, 3, 0);
        queue_item(ACT_ADD, 7, 0, 214748364, 1);
        queue_item(ACT_ADD, 1, -128, -1, 127);
        queue_item(ACT_ADD, 0, 127, 0, -128);
        queue_item(ACT_ADD, 214748364, 1, 0, 0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sa = int'($urandom_range(255)) - 128;
            case ($urandom_range(9))
                0: sb = int'($urandom_range(255)) - 128;
                1: sb = sa;
                default: sb = clamp_scale(sa + int'($urandom_range(24)) - 12);
            endcase
            queue_item($urandom_range(1) ? ACT_ADD : ACT_RESCALE,
                       pick_mantissa(), sa, pick_mantissa(), sb);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || req.valid || results_due.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        $display("covered %0d rescale and %0d add transactions, %0d checked, %0d overflowed",
                 rescale_count, add_count, checked_count, overflow_count);
        $display("stalls: light sender/heavy receiver, reversed, none; two full drains");
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> decimal_scaled_add_unit.f
hdl/dsa_pkg.sv
hdl/dsa_if.sv
hdl/dsa_step_unit.sv
hdl/decimal_scaled_add_unit.sv
test/tb.sv
